// ----- rtl/core/mad_mri_pkg.sv -----
// Shared constants and helpers for the Madaline MRI training step block.
package mad_mri_pkg;

  // Default storage width of hidden weights and biases
  localparam int WEIGHT_WIDTH_DEF = 16;

  // Fixed-point format and port widths
  localparam int FRAC_BITS = 12;
  localparam int ONE_Q     = 4096;
  localparam int BIP_W     = 2;
  localparam int LR_W      = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int FIELD_W   = 16;

  // Bipolar output codes
  localparam logic [BIP_W-1:0] BIP_POS = 2'b01;
  localparam logic [BIP_W-1:0] BIP_NEG = 2'b11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_W1     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_W2     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BIAS   = 2'd3;

  // Reset values, Q4.12
  localparam int W11_INIT      = 205;
  localparam int W12_INIT      = 410;
  localparam int W21_INIT      = 819;
  localparam int W22_INIT      = 819;
  localparam int B1_INIT       = 1229;
  localparam int B2_INIT       = 614;
  localparam int LR_INIT       = 2048;
  localparam int OUT_W1_INIT   = 2048;
  localparam int OUT_W2_INIT   = 2048;
  localparam int OUT_BIAS_INIT = 2048;

  // Clamp an elaboration-time value to a signed range of the given width
  function automatic longint sat_init(input longint v, input int ww);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ww - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/madaline_mri_training_step_top.sv -----
// Top level of the 2-2-1 Madaline MRI training step block.
//
// One bipolar training word (x1, x2, target) enters per cycle while in_stall is
// low; it is held in an input register, and the logic after it forms both hidden
// nets, the network output, the MRI update decision and the saturated weight
// update, writing the result register and the hidden weights at the same edge.
// Throughput is one word per clock while out_stall is low; a word reaches
// out_valid through the input register, then the result register. The cycle is
// set by the feedback path from the weight registers through the nets, the
// learn-rate multiply and the saturating add back into the weights.
// Output weight fields show the low 16 bits of each stored weight, sign
// extended when WEIGHT_WIDTH is below 16. Configuration writes take effect at
// once and are meant for idle periods.
module madaline_mri_training_step_top #(
  parameter int WEIGHT_WIDTH = mad_mri_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mad_mri_pkg::BIP_W-1:0]   in_sample_x1,
  input  logic signed [mad_mri_pkg::BIP_W-1:0]   in_sample_x2,
  input  logic signed [mad_mri_pkg::BIP_W-1:0]   in_target_class,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mad_mri_pkg::BIP_W-1:0]   out_predicted,
  output logic signed [mad_mri_pkg::BIP_W-1:0]   out_hidden_sign_one,
  output logic signed [mad_mri_pkg::BIP_W-1:0]   out_hidden_sign_two,
  output logic        [mad_mri_pkg::BIP_W-1:0]   out_updated_mask,
  output logic signed [mad_mri_pkg::FIELD_W-1:0] out_new_w11,
  output logic signed [mad_mri_pkg::FIELD_W-1:0] out_new_w12,
  output logic signed [mad_mri_pkg::FIELD_W-1:0] out_new_w21,
  output logic signed [mad_mri_pkg::FIELD_W-1:0] out_new_w22,
  output logic signed [mad_mri_pkg::FIELD_W-1:0] out_new_b1,
  output logic signed [mad_mri_pkg::FIELD_W-1:0] out_new_b2,
  // configuration port
  input  logic                                   cfg_wr_en,
  input  logic        [mad_mri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [mad_mri_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int WW   = WEIGHT_WIDTH;
  localparam int FW   = mad_mri_pkg::FIELD_W;
  localparam int NW   = WW + 2;                    // hidden net width
  localparam int DW   = ((NW > 14) ? NW : 14) + 1; // target minus net
  localparam int PW   = DW + mad_mri_pkg::LR_W + 1; // learn-rate product
  localparam int DPW  = PW + 1 - mad_mri_pkg::FRAC_BITS; // rounded step
  localparam int SW   = ((DPW > WW) ? DPW : WW) + 2; // update sum
  localparam int YW   = mad_mri_pkg::CFG_W + 2;     // output net width

  localparam logic signed [WW-1:0] W11_RST =
    WW'(mad_mri_pkg::sat_init(mad_mri_pkg::W11_INIT, WW));
  localparam logic signed [WW-1:0] W12_RST =
    WW'(mad_mri_pkg::sat_init(mad_mri_pkg::W12_INIT, WW));
  localparam logic signed [WW-1:0] W21_RST =
    WW'(mad_mri_pkg::sat_init(mad_mri_pkg::W21_INIT, WW));
  localparam logic signed [WW-1:0] W22_RST =
    WW'(mad_mri_pkg::sat_init(mad_mri_pkg::W22_INIT, WW));
  localparam logic signed [WW-1:0] B1_RST =
    WW'(mad_mri_pkg::sat_init(mad_mri_pkg::B1_INIT, WW));
  localparam logic signed [WW-1:0] B2_RST =
    WW'(mad_mri_pkg::sat_init(mad_mri_pkg::B2_INIT, WW));

  localparam logic signed [SW-1:0] W_MAX = SW'((longint'(1) <<< (WW - 1)) - 1);
  localparam logic signed [SW-1:0] W_MIN = SW'(-(longint'(1) <<< (WW - 1)));
  localparam logic signed [DW-1:0] ONE_Q_D = DW'(mad_mri_pkg::ONE_Q);
  localparam logic signed [PW:0]   HALF_Q  = (PW + 1)'(mad_mri_pkg::ONE_Q / 2);

  // Add a signed step, optionally negated, and clamp to the weight range
  function automatic logic signed [WW-1:0] sat_upd(
    input logic signed [WW-1:0]  w,
    input logic signed [DPW-1:0] d,
    input logic                  neg
  );
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] sum;
    dx  = neg ? -SW'(d) : SW'(d);
    sum = SW'(w) + dx;
    if (sum > W_MAX) begin
      return W_MAX[WW-1:0];
    end
    if (sum < W_MIN) begin
      return W_MIN[WW-1:0];
    end
    return sum[WW-1:0];
  endfunction

  // Low 16 bits of a stored weight, sign extended when narrower
  function automatic logic signed [FW-1:0] to_field(input logic signed [WW-1:0] w);
    logic signed [WW+FW-1:0] ext;
    ext = (WW + FW)'(w);
    return ext[FW-1:0];
  endfunction

  // Configuration registers
  logic        [mad_mri_pkg::LR_W-1:0]  learn_rate_r;
  logic signed [mad_mri_pkg::CFG_W-1:0] out_w1_r;
  logic signed [mad_mri_pkg::CFG_W-1:0] out_w2_r;
  logic signed [mad_mri_pkg::CFG_W-1:0] out_bias_r;

  // Hidden weights and biases
  logic signed [WW-1:0] w11_r, w12_r, w21_r, w22_r, b1_r, b2_r;
  logic signed [WW-1:0] w11_nxt, w12_nxt, w21_nxt, w22_nxt, b1_nxt, b2_nxt;

  // Input register
  logic s1_valid_r;
  logic s1_x1_neg_r, s1_x2_neg_r, s1_t_neg_r;

  // Result register
  logic                                 out_valid_r;
  logic [mad_mri_pkg::BIP_W-1:0]        pred_r, hs1_r, hs2_r, mask_r;
  logic signed [FW-1:0]                 nw11_r, nw12_r, nw21_r, nw22_r, nb1_r, nb2_r;

  logic advance;

  // Datapath between the input and result registers
  logic signed [NW-1:0]  net1, net2;
  logic                  z1_neg, z2_neg, y_neg;
  logic signed [YW-1:0]  ynet;
  logic        [NW-1:0]  abs1, abs2;
  logic [1:0]            mask;
  logic signed [DW-1:0]  t_q, diff1, diff2;
  logic signed [PW-1:0]  prod1, prod2;
  logic signed [PW:0]    rnd1, rnd2;
  logic signed [DPW-1:0] d1, d2;

  // Stall only when the input register is full and cannot move on
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;

  always_comb begin
    // hidden nets, bipolar inputs turn products into add or subtract
    net1 = NW'(b1_r) + (s1_x1_neg_r ? -NW'(w11_r) : NW'(w11_r))
                     + (s1_x2_neg_r ? -NW'(w21_r) : NW'(w21_r));
    net2 = NW'(b2_r) + (s1_x1_neg_r ? -NW'(w12_r) : NW'(w12_r))
                     + (s1_x2_neg_r ? -NW'(w22_r) : NW'(w22_r));
    z1_neg = net1[NW-1];
    z2_neg = net2[NW-1];

    // output unit with fixed weights
    ynet = YW'(out_bias_r) + (z1_neg ? -YW'(out_w1_r) : YW'(out_w1_r))
                           + (z2_neg ? -YW'(out_w2_r) : YW'(out_w2_r));
    y_neg = ynet[YW-1];

    // MRI unit selection on a miss
    abs1 = z1_neg ? NW'(-net1) : NW'(net1);
    abs2 = z2_neg ? NW'(-net2) : NW'(net2);
    mask = 2'b00;
    if (y_neg != s1_t_neg_r) begin
      if (s1_t_neg_r) begin
        mask[0] = ~z1_neg & (net1 != '0);
        mask[1] = ~z2_neg & (net2 != '0);
      end else begin
        mask[0] = (abs1 <= abs2);
        mask[1] = (abs1 >= abs2);
      end
    end

    // step = learn_rate * (t - net), rounded to Q.12, ties up
    t_q   = s1_t_neg_r ? -ONE_Q_D : ONE_Q_D;
    diff1 = t_q - DW'(net1);
    diff2 = t_q - DW'(net2);
    prod1 = PW'($signed({1'b0, learn_rate_r}) * diff1);
    prod2 = PW'($signed({1'b0, learn_rate_r}) * diff2);
    rnd1  = (PW + 1)'(prod1) + HALF_Q;
    rnd2  = (PW + 1)'(prod2) + HALF_Q;
    d1    = rnd1[PW:mad_mri_pkg::FRAC_BITS];
    d2    = rnd2[PW:mad_mri_pkg::FRAC_BITS];

    // saturating updates
    w11_nxt = mask[0] ? sat_upd(w11_r, d1, s1_x1_neg_r) : w11_r;
    w21_nxt = mask[0] ? sat_upd(w21_r, d1, s1_x2_neg_r) : w21_r;
    b1_nxt  = mask[0] ? sat_upd(b1_r, d1, 1'b0)         : b1_r;
    w12_nxt = mask[1] ? sat_upd(w12_r, d2, s1_x1_neg_r) : w12_r;
    w22_nxt = mask[1] ? sat_upd(w22_r, d2, s1_x2_neg_r) : w22_r;
    b2_nxt  = mask[1] ? sat_upd(b2_r, d2, 1'b0)         : b2_r;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= mad_mri_pkg::LR_W'(mad_mri_pkg::LR_INIT);
      out_w1_r     <= mad_mri_pkg::CFG_W'(mad_mri_pkg::OUT_W1_INIT);
      out_w2_r     <= mad_mri_pkg::CFG_W'(mad_mri_pkg::OUT_W2_INIT);
      out_bias_r   <= mad_mri_pkg::CFG_W'(mad_mri_pkg::OUT_BIAS_INIT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mad_mri_pkg::CFG_LEARN_RATE: learn_rate_r <= cfg_wdata[mad_mri_pkg::LR_W-1:0];
        mad_mri_pkg::CFG_OUT_W1:     out_w1_r     <= cfg_wdata;
        mad_mri_pkg::CFG_OUT_W2:     out_w2_r     <= cfg_wdata;
        mad_mri_pkg::CFG_OUT_BIAS:   out_bias_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hidden weights: advance with each processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w11_r <= W11_RST;
      w12_r <= W12_RST;
      w21_r <= W21_RST;
      w22_r <= W22_RST;
      b1_r  <= B1_RST;
      b2_r  <= B2_RST;
    end else if (advance) begin
      w11_r <= w11_nxt;
      w12_r <= w12_nxt;
      w21_r <= w21_nxt;
      w22_r <= w22_nxt;
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
    end
  end

  // Input register: load on accept, drop when moved on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_x1_neg_r <= in_sample_x1[1];
      s1_x2_neg_r <= in_sample_x2[1];
      s1_t_neg_r  <= in_target_class[1];
    end
  end

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pred_r <= y_neg  ? mad_mri_pkg::BIP_NEG : mad_mri_pkg::BIP_POS;
      hs1_r  <= z1_neg ? mad_mri_pkg::BIP_NEG : mad_mri_pkg::BIP_POS;
      hs2_r  <= z2_neg ? mad_mri_pkg::BIP_NEG : mad_mri_pkg::BIP_POS;
      mask_r <= mask;
      nw11_r <= to_field(w11_nxt);
      nw12_r <= to_field(w12_nxt);
      nw21_r <= to_field(w21_nxt);
      nw22_r <= to_field(w22_nxt);
      nb1_r  <= to_field(b1_nxt);
      nb2_r  <= to_field(b2_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted       = pred_r;
  assign out_hidden_sign_one = hs1_r;
  assign out_hidden_sign_two = hs2_r;
  assign out_updated_mask    = mask_r;
  assign out_new_w11         = nw11_r;
  assign out_new_w12         = nw12_r;
  assign out_new_w21         = nw21_r;
  assign out_new_w22         = nw22_r;
  assign out_new_b1          = nb1_r;
  assign out_new_b2          = nb2_r;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the 2-2-1 Madaline MRI training step block.
module testbench;
  import mad_mri_pkg::*;

  localparam int LATENCY     = 2;
  localparam int HOLD_LEN    = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int WW          = WEIGHT_WIDTH_DEF;

  // One result word of the block
  typedef struct {
    logic signed [BIP_W-1:0]   predicted;
    logic signed [BIP_W-1:0]   sign_one;
    logic signed [BIP_W-1:0]   sign_two;
    logic        [BIP_W-1:0]   mask;
    logic signed [FIELD_W-1:0] w11;
    logic signed [FIELD_W-1:0] w12;
    logic signed [FIELD_W-1:0] w21;
    logic signed [FIELD_W-1:0] w22;
    logic signed [FIELD_W-1:0] b1;
    logic signed [FIELD_W-1:0] b2;
  } step_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [BIP_W-1:0]     in_sample_x1 = BIP_POS;
  logic signed [BIP_W-1:0]     in_sample_x2 = BIP_POS;
  logic signed [BIP_W-1:0]     in_target_class = BIP_POS;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [BIP_W-1:0]     out_predicted;
  logic signed [BIP_W-1:0]     out_hidden_sign_one;
  logic signed [BIP_W-1:0]     out_hidden_sign_two;
  logic        [BIP_W-1:0]     out_updated_mask;
  logic signed [FIELD_W-1:0]   out_new_w11;
  logic signed [FIELD_W-1:0]   out_new_w12;
  logic signed [FIELD_W-1:0]   out_new_w21;
  logic signed [FIELD_W-1:0]   out_new_w22;
  logic signed [FIELD_W-1:0]   out_new_b1;
  logic signed [FIELD_W-1:0]   out_new_b2;
  logic                        cfg_wr_en = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_index = CFG_LEARN_RATE;
  logic        [CFG_W-1:0]     cfg_wdata = '0;

  // Mirror of the trained weights and the output-unit settings
  longint hid_w[4] = '{W11_INIT, W12_INIT, W21_INIT, W22_INIT};
  longint hid_b[2] = '{B1_INIT, B2_INIT};
  longint lr_q     = LR_INIT;
  longint ow_one   = OUT_W1_INIT;
  longint ow_two   = OUT_W2_INIT;
  longint o_bias   = OUT_BIAS_INIT;

  step_result_t exp_results[$];
  int           mismatch_count = 0;
  int           result_count = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  logic         hold_tog = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_left = 0;

  madaline_mri_training_step_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_x1        (in_sample_x1),
    .in_sample_x2        (in_sample_x2),
    .in_target_class     (in_target_class),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted       (out_predicted),
    .out_hidden_sign_one (out_hidden_sign_one),
    .out_hidden_sign_two (out_hidden_sign_two),
    .out_updated_mask    (out_updated_mask),
    .out_new_w11         (out_new_w11),
    .out_new_w12         (out_new_w12),
    .out_new_w21         (out_new_w21),
    .out_new_w22         (out_new_w22),
    .out_new_b1          (out_new_b1),
    .out_new_b2          (out_new_b2),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Only the sign bit of a bipolar code matters: 0 reads as +1, -2 as -1
  function automatic longint bipolar_value(logic [BIP_W-1:0] code);
    return code[BIP_W-1] ? -1 : 1;
  endfunction

  function automatic logic [BIP_W-1:0] sign_code(longint v);
    return (v >= 0) ? BIP_POS : BIP_NEG;
  endfunction

  function automatic longint sat_weight(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (WW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Move one hidden unit toward the target; arithmetic shift of the biased
  // Q.24 product rounds to nearest with ties toward plus infinity
  function automatic void train_unit(int k, longint t, longint net, longint x1, longint x2);
    longint step;
    step = (lr_q * (t * ONE_Q - net) + ONE_Q / 2) >>> FRAC_BITS;
    hid_w[k]     = sat_weight(hid_w[k] + step * x1);
    hid_w[2 + k] = sat_weight(hid_w[2 + k] + step * x2);
    hid_b[k]     = sat_weight(hid_b[k] + step);
  endfunction

  // Apply one training sample to the mirror and return the word it yields
  function automatic step_result_t mri_train_step(logic [BIP_W-1:0] x1c,
                                                  logic [BIP_W-1:0] x2c,
                                                  logic [BIP_W-1:0] tc);
    longint x1;
    longint x2;
    longint t;
    longint net1;
    longint net2;
    longint z1;
    longint z2;
    longint y;
    longint a1;
    longint a2;
    logic [BIP_W-1:0] mask;
    step_result_t r;
    x1   = bipolar_value(x1c);
    x2   = bipolar_value(x2c);
    t    = bipolar_value(tc);
    net1 = hid_w[0] * x1 + hid_w[2] * x2 + hid_b[0];
    net2 = hid_w[1] * x1 + hid_w[3] * x2 + hid_b[1];
    z1   = (net1 >= 0) ? 1 : -1;
    z2   = (net2 >= 0) ? 1 : -1;
    y    = ((z1 * ow_one + z2 * ow_two + o_bias) >= 0) ? 1 : -1;
    mask = '0;
    if (y != t) begin
      if (t < 0) begin
        mask[0] = (net1 > 0);
        mask[1] = (net2 > 0);
      end else begin
        a1 = (net1 < 0) ? -net1 : net1;
        a2 = (net2 < 0) ? -net2 : net2;
        mask[0] = (a1 <= a2);
        mask[1] = (a1 >= a2);
      end
    end
    if (mask[0]) begin
      train_unit(0, t, net1, x1, x2);
    end
    if (mask[1]) begin
      train_unit(1, t, net2, x1, x2);
    end
    r.predicted = sign_code(y);
    r.sign_one  = sign_code(z1);
    r.sign_two  = sign_code(z2);
    r.mask      = mask;
    r.w11       = hid_w[0][FIELD_W-1:0];
    r.w12       = hid_w[1][FIELD_W-1:0];
    r.w21       = hid_w[2][FIELD_W-1:0];
    r.w22       = hid_w[3][FIELD_W-1:0];
    r.b1        = hid_b[0][FIELD_W-1:0];
    r.b2        = hid_b[1][FIELD_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [FIELD_W-1:0] exp_v,
                                      logic signed [FIELD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("word %0d: %s expected %0d, got %0d", result_count, name, exp_v, act_v);
      end
    end
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : chk_result
    step_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("word %0d: result with nothing expected", result_count);
        end
      end else begin
        want = exp_results.pop_front();
        check_field("predicted", want.predicted, out_predicted);
        check_field("hidden_sign_one", want.sign_one, out_hidden_sign_one);
        check_field("hidden_sign_two", want.sign_two, out_hidden_sign_two);
        check_field("updated_mask", {14'd0, want.mask}, {14'd0, out_updated_mask});
        check_field("new_w11", want.w11, out_new_w11);
        check_field("new_w12", want.w12, out_new_w12);
        check_field("new_w21", want.w21, out_new_w21);
        check_field("new_w22", want.w22, out_new_w22);
        check_field("new_b1", want.b1, out_new_b1);
        check_field("new_b2", want.b2, out_new_b2);
      end
      result_count++;
    end
  end

  // Drive the receiver stall: a requested hold-off first, else random
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Offer one training word, hold it until accepted, then record its result
  task automatic send_word(input logic [BIP_W-1:0] x1, input logic [BIP_W-1:0] x2,
                           input logic [BIP_W-1:0] t);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_x1    <= x1;
    in_sample_x2    <= x2;
    in_target_class <= t;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    exp_results.push_back(mri_train_step(x1, x2, t));
  endtask

  // Stop sending and wait until every expected word has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_LEARN_RATE: lr_q   = longint'(value[LR_W-1:0]);
      CFG_OUT_W1:     ow_one = longint'($signed(value));
      CFG_OUT_W2:     ow_two = longint'($signed(value));
      CFG_OUT_BIAS:   o_bias = longint'($signed(value));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
      end
      1: begin
        tx_idle_pct  = 50;
        rx_stall_pct <= 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct <= 50;
      end
      default: begin
        tx_idle_pct  = 23;
        rx_stall_pct <= 23;
      end
    endcase
  endtask

  // Encode a bipolar sign, now and then with the out-of-range alias
  function automatic logic [BIP_W-1:0] bipolar_code(bit negative);
    if ($urandom_range(9) == 0) begin
      return negative ? 2'b10 : 2'b00;
    end
    return negative ? BIP_NEG : BIP_POS;
  endfunction

  function automatic logic [CFG_W-1:0] pick_out_value();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'(OUT_W1_INIT);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Every sample and target at reset settings, plus out-of-range codes
  task automatic test_reset_defaults();
    int i;
    set_idling(0);
    for (i = 0; i < 8; i++) begin
      send_word(i[0] ? BIP_NEG : BIP_POS, i[1] ? BIP_NEG : BIP_POS,
                i[2] ? BIP_NEG : BIP_POS);
    end
    send_word(2'b00, 2'b00, 2'b00);
    send_word(2'b10, 2'b10, 2'b10);
    send_word(2'b00, 2'b10, 2'b10);
    send_word(2'b10, 2'b00, 2'b00);
    wait_results_drained();
  endtask

  // Largest learn rate with extreme output weights, then zero learn rate
  task automatic test_config_extremes();
    int i;
    write_cfg(CFG_LEARN_RATE, 16'hFFFF);
    write_cfg(CFG_OUT_W1, 16'h8000);
    write_cfg(CFG_OUT_W2, 16'h7FFF);
    write_cfg(CFG_OUT_BIAS, 16'h7FFF);
    for (i = 0; i < 6; i++) begin
      send_word(i[0] ? BIP_NEG : BIP_POS, i[1] ? BIP_NEG : BIP_POS,
                (i < 3) ? BIP_NEG : BIP_POS);
    end
    wait_results_drained();
    write_cfg(CFG_LEARN_RATE, 16'h0000);
    write_cfg(CFG_OUT_W1, 16'h7FFF);
    write_cfg(CFG_OUT_W2, 16'h7FFF);
    write_cfg(CFG_OUT_BIAS, 16'h8000);
    for (i = 0; i < 6; i++) begin
      send_word(i[1] ? BIP_NEG : BIP_POS, i[0] ? BIP_NEG : BIP_POS,
                i[0] ? BIP_POS : BIP_NEG);
    end
    wait_results_drained();
  endtask

  // Hold off the receiver long enough for the block to stall its input
  task automatic test_backpressure();
    int i;
    write_cfg(CFG_LEARN_RATE, 16'(LR_INIT));
    write_cfg(CFG_OUT_W1, 16'(OUT_W1_INIT));
    write_cfg(CFG_OUT_W2, 16'(OUT_W2_INIT));
    write_cfg(CFG_OUT_BIAS, 16'(OUT_BIAS_INIT));
    set_idling(0);
    hold_tog <= ~hold_tog;
    for (i = 0; i < 40; i++) begin
      send_word(2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
    end
    wait_results_drained();
  endtask

  // Shuffled epochs of four-sample problems under random settings, with noise
  task automatic test_random_training();
    int  phase;
    int  sent;
    int  kind;
    int  i;
    int  j;
    int  tmp;
    int  order[4];
    bit  t_neg;
    logic [CFG_W-1:0] lr_val;
    for (phase = 0; phase < 12; phase++) begin
      wait_results_drained();
      case ($urandom_range(4))
        0:       lr_val = 16'h0000;
        1:       lr_val = 16'h7FFF;
        2:       lr_val = 16'(LR_INIT);
        default: lr_val = 16'($urandom_range(8191));
      endcase
      lr_val[CFG_W-1] = 1'($urandom_range(1));
      write_cfg(CFG_LEARN_RATE, lr_val);
      write_cfg(CFG_OUT_W1, pick_out_value());
      write_cfg(CFG_OUT_W2, pick_out_value());
      write_cfg(CFG_OUT_BIAS, pick_out_value());
      set_idling(phase);
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(9) < 8) begin
          kind = $urandom_range(3);
          for (i = 0; i < 4; i++) begin
            order[i] = i;
          end
          for (i = 3; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          for (i = 0; i < 4; i++) begin
            // bit 0 marks x1 negative, bit 1 marks x2 negative
            case (kind)
              0:       t_neg = (order[i][0] == order[i][1]);
              1:       t_neg = order[i][0] | order[i][1];
              2:       t_neg = order[i][0] & order[i][1];
              default: t_neg = 1'($urandom_range(1));
            endcase
            send_word(bipolar_code(order[i][0]), bipolar_code(order[i][1]),
                      bipolar_code(t_neg));
            sent++;
          end
        end else begin
          send_word(2'($urandom_range(3)), 2'($urandom_range(3)),
                    2'($urandom_range(3)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_training();
    wait_results_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && exp_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
